[src/bspc_pkg.sv]
package bspc_pkg;

  // Register file geometry
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DelayW   = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_SHORT    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_LONG     = CfgIdxW'(3);

  // Reset values of the delay registers
  localparam logic [DelayW-1:0] DEBOUNCE_RST = DelayW'(40);
  localparam logic [DelayW-1:0] SHORT_RST    = DelayW'(400);
  localparam logic [DelayW-1:0] LONG_RST     = DelayW'(4000);

  localparam logic [DelayW-1:0] COUNT_MAX = '1;

  // Evaluation stage codes
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DEBOUNCE = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_LONG     = 2'd3;

  typedef struct packed {
    logic              enable;
    logic [DelayW-1:0] debounce_delay;
    logic [DelayW-1:0] short_delay;
    logic [DelayW-1:0] long_delay;
  } cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic busy_res;
  } res_t;

endpackage

[src/bspc_if.sv]
interface bspc_in_if;
  logic valid;
  logic ready;
  logic edge_seen;
  logic pin_level;

  modport source (output valid, output edge_seen, output pin_level, input ready);
  modport sink   (input valid, input edge_seen, input pin_level, output ready);
endinterface

interface bspc_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic busy_res;

  modport source (output valid, output short_press, output long_press, output busy_res,
                  input ready);
  modport sink   (input valid, input short_press, input long_press, input busy_res,
                  output ready);
endinterface

interface bspc_cfg_if import bspc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/button_short_long_press_classifier_top.sv]
// Debounced short/long button press classifier. Each input transfer is one
// timer tick carrying the edge-interrupt flag and the sampled pin (low means
// pressed); each tick yields exactly one result transfer with short_press,
// long_press and busy_res. An enabled edge restarts the evaluation in the
// debounce stage; each stage expires on the tick its counter reaches the
// stage's delay, then the pin decides the next stage or the press type.
// Throughput is one tick per clock: the tick is held in an input register,
// the stage and counter update in one pass of logic, and the result is held
// in an output register, so a new tick is taken while a result waits as long
// as the output side drains. A tick's result passes the input register and
// then the output register. The configuration port always accepts; write it
// only while no tick is in flight. Register indexes: 0 enable, 1 debounce_delay,
// 2 short_delay, 3 long_delay; other indexes are dropped.
module button_short_long_press_classifier_top import bspc_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  bspc_in_if.sink      in_i,
  bspc_out_if.source   out_o,
  bspc_cfg_if.sink     cfg_i
);

  cfg_t cfg;
  res_t res, out_res;
  logic res_valid, res_ready;

  // Configuration registers
  bspc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Input register, stage and counter update
  bspc_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .edge_seen_i (in_i.edge_seen),
    .pin_level_i (in_i.pin_level),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Result register towards the output channel
  bspc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_res)
  );

  assign out_o.short_press = out_res.short_press;
  assign out_o.long_press  = out_res.long_press;
  assign out_o.busy_res    = out_res.busy_res;

endmodule

[src/bspc_cfg_regs.sv]
module bspc_cfg_regs import bspc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_ENABLE:   cfg_d.enable         = wr_data_i[0];
        REG_DEBOUNCE: cfg_d.debounce_delay = DelayW'(wr_data_i);
        REG_SHORT:    cfg_d.short_delay    = DelayW'(wr_data_i);
        REG_LONG:     cfg_d.long_delay     = DelayW'(wr_data_i);
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.debounce_delay <= DEBOUNCE_RST;
      cfg_q.short_delay    <= SHORT_RST;
      cfg_q.long_delay     <= LONG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/bspc_eval.sv]
module bspc_eval import bspc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic edge_seen_i,
  input  logic pin_level_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  logic              valid_q;
  logic              edge_q, pin_q;
  logic [1:0]        stage_q, stage_d;
  logic [DelayW-1:0] count_q, count_d;
  logic [DelayW-1:0] count_inc, delay;
  logic              advance, pressed;

  assign advance    = valid_q && res_ready_i;
  assign in_ready_o = !valid_q || res_ready_i;
  assign pressed    = !pin_q;

  assign count_inc = (count_q != COUNT_MAX) ? count_q + DelayW'(1) : count_q;

  always_comb begin
    case (stage_q)
      ST_DEBOUNCE: delay = cfg_i.debounce_delay;
      ST_SHORT:    delay = cfg_i.short_delay;
      default:     delay = cfg_i.long_delay;
    endcase
  end

  always_comb begin
    stage_d           = stage_q;
    count_d           = count_q;
    res_o.short_press = 1'b0;
    res_o.long_press  = 1'b0;
    if (edge_q && cfg_i.enable) begin
      // restart at debounce, no check on this tick
      stage_d = ST_DEBOUNCE;
      count_d = '0;
    end else if (stage_q != ST_IDLE) begin
      count_d = count_inc;
      if (count_inc >= delay) begin
        count_d = '0;
        stage_d = ST_IDLE;
        case (stage_q)
          ST_DEBOUNCE: begin
            if (pressed) stage_d = ST_SHORT;
          end
          ST_SHORT: begin
            if (pressed) stage_d = ST_LONG;
            else res_o.short_press = 1'b1;
          end
          default: begin
            res_o.long_press  = pressed;
            res_o.short_press = !pressed;
          end
        endcase
      end
    end
    res_o.busy_res = (stage_d != ST_IDLE);
  end

  assign res_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      stage_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      if (in_ready_o) valid_q <= in_valid_i;
      if (advance) begin
        stage_q <= stage_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      edge_q <= edge_seen_i;
      pin_q  <= pin_level_i;
    end
  end

endmodule

[src/bspc_out_reg.sv]
module bspc_out_reg import bspc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  output logic res_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  logic valid_q;
  res_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import bspc_pkg::*;

  // Result shapes that can be read off directly
  localparam res_t RES_IDLE  = 3'b000;
  localparam res_t RES_BUSY  = 3'b001;
  localparam res_t RES_SHORT = 3'b100;
  localparam res_t RES_LONG  = 3'b010;

  // An index the register file has no slot for
  localparam logic [CfgIdxW-1:0] REG_NONE = CfgIdxW'(200);

  // Cycles to let pass after the last result before touching a register
  localparam int SETTLE_CYC = 4;
  // Long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYC = 150;
  // Pressed ticks sent under the widest delays, all well short of expiry
  localparam int WIDE_TICKS = 40;
  // Run ceiling in clock cycles
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] val;
    logic               edge_seen;
    logic               pin_level;
    logic               typed;
    res_t               want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  bspc_in_if  in_if ();
  bspc_out_if out_if ();
  bspc_cfg_if cfg_if ();

  button_short_long_press_classifier_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the classifier: register copy, stage and tick counter
  cfg_t              cfg_m;
  logic [1:0]        stage_m;
  logic [DelayW-1:0] ticks_m;

  // Results owed by the block, oldest first
  res_t awaited_res[$];
  res_t want_r;

  row_t        plan[$];
  int          ticks_sent;
  int          fail_cnt;
  int unsigned cycle_cnt;
  bit          quiet;
  bit          hold_out;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset low, then release it on a falling edge
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Abandon the run if it drags on far past any correct finish
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Press classification, one timer tick at a time
  // ---------------------------------------------------------------------------
  function automatic res_t classify_tick(input logic edge_seen, input logic pin_level);
    res_t              r;
    logic [DelayW-1:0] limit;
    r = RES_IDLE;
    if (edge_seen && cfg_m.enable) begin
      // An enabled edge restarts the evaluation, with no count and no pin check
      ticks_m = '0;
      stage_m = ST_DEBOUNCE;
    end else if (stage_m != ST_IDLE) begin
      if (ticks_m != COUNT_MAX) ticks_m = ticks_m + 1'b1;
      limit = (stage_m == ST_DEBOUNCE) ? cfg_m.debounce_delay :
              (stage_m == ST_SHORT)    ? cfg_m.short_delay    : cfg_m.long_delay;
      // Greater-or-equal, so a zero delay expires on the first counted tick
      if (ticks_m >= limit) begin
        case (stage_m)
          ST_DEBOUNCE: begin
            stage_m = pin_level ? ST_IDLE : ST_SHORT;
          end
          ST_SHORT: begin
            r.short_press = pin_level;
            stage_m = pin_level ? ST_IDLE : ST_LONG;
          end
          default: begin
            r.long_press  = ~pin_level;
            r.short_press = pin_level;
            stage_m = ST_IDLE;
          end
        endcase
        ticks_m = '0;
      end
    end
    r.busy_res = (stage_m != ST_IDLE);
    return r;
  endfunction

  function automatic logic [DelayW-1:0] pick_delay();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DelayW'(1);
      default: return DelayW'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic void plan_write(input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDataW-1:0] val);
    row_t r;
    r = '{ROW_WRITE, idx, val, 1'b0, 1'b1, 1'b0, RES_IDLE};
    plan.push_back(r);
  endfunction

  function automatic void plan_tick(input logic edge_seen, input logic pin_level,
                                    input logic typed = 1'b0, input res_t want = RES_IDLE);
    row_t r;
    r = '{ROW_TICK, '0, '0, edge_seen, pin_level, typed, want};
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one tick, hold it until the transfer, record what it owes
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic edge_seen, input logic pin_level,
                           input logic typed = 1'b0, input res_t want = RES_IDLE);
    res_t got;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.edge_seen <= edge_seen;
    in_if.pin_level <= pin_level;
    do @(posedge clk_i); while (!in_if.ready);
    got = classify_tick(edge_seen, pin_level);
    // Typed rows advance the mirror but are held to the value written in the plan
    awaited_res.push_back(typed ? want : got);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering, let every owed result arrive, then give the block a margin
  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_res.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Register writes only go in once the block has gone quiet
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_ENABLE:   cfg_m.enable         = val[0];
      REG_DEBOUNCE: cfg_m.debounce_delay = val;
      REG_SHORT:    cfg_m.short_delay    = val;
      REG_LONG:     cfg_m.long_delay     = val;
      default:      ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly clean presses held for random lengths, with bursts of bounce noise
  task automatic run_phase(input logic en, input logic [DelayW-1:0] deb,
                           input logic [DelayW-1:0] shrt, input logic [DelayW-1:0] lng,
                           input int n, input bit hold = 1'b0);
    int span;
    int stop;
    write_reg(REG_ENABLE, CfgDataW'(en));
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_SHORT, shrt);
    write_reg(REG_LONG, lng);
    // Start the receiver's long hold-off only now, so the sender keeps offering
    if (hold) hold_out = 1'b1;
    span = int'(deb) + int'(shrt) + int'(lng) + 3;
    stop = ticks_sent + n;
    while (ticks_sent < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        send_tick(1'b1, 1'b0);
        repeat ($urandom_range(0, span)) send_tick(1'b0, 1'b0);
        repeat ($urandom_range(1, span)) send_tick(1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    cfg_m   = '{enable: 1'b0, debounce_delay: DEBOUNCE_RST,
                short_delay: SHORT_RST, long_delay: LONG_RST};
    stage_m = ST_IDLE;
    ticks_m = '0;
    in_if.valid     <= 1'b0;
    in_if.edge_seen <= 1'b0;
    in_if.pin_level <= 1'b1;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;

    // Out of reset the block is disabled, so an edge must leave it idle
    plan_tick(1'b1, 1'b0, 1'b1, RES_IDLE);
    plan_write(REG_ENABLE, CfgDataW'(1));
    plan_write(REG_NONE, '1);
    plan_write(REG_DEBOUNCE, CfgDataW'(1));
    plan_write(REG_SHORT, CfgDataW'(2));
    plan_write(REG_LONG, CfgDataW'(1));
    // Full hold through all three stages ends in a long press
    plan_tick(1'b1, 1'b1, 1'b1, RES_BUSY);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b0, 1'b1, RES_LONG);
    // Released at the debounce check: a bounce, dropped without a press
    plan_tick(1'b1, 1'b1);
    plan_tick(1'b0, 1'b1, 1'b1, RES_IDLE);
    // Released at the second check: short press
    plan_tick(1'b1, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b1);
    plan_tick(1'b0, 1'b1, 1'b1, RES_SHORT);
    // Zero debounce delay, released during the third stage: short press
    plan_write(REG_DEBOUNCE, '0);
    plan_tick(1'b1, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b0, 1'b1, 1'b1, RES_SHORT);
    // A fresh edge mid-evaluation restarts from the debounce stage
    plan_tick(1'b1, 1'b0);
    plan_tick(1'b0, 1'b0);
    plan_tick(1'b1, 1'b1, 1'b1, RES_BUSY);
    plan_tick(1'b0, 1'b1, 1'b1, RES_IDLE);

    wait (rst_ni);
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(plan[i].edge_seen, plan[i].pin_level, plan[i].typed, plan[i].want);
      end
    end

    // Random phases; the first runs disabled so every edge is ignored
    for (int ph = 0; ph < 8; ph++) begin
      run_phase(ph != 0, pick_delay(), pick_delay(), pick_delay(), 75, ph == 3);
    end

    // Last stretch without idling: widest delays, then one more random phase
    quiet = 1'b1;
    write_reg(REG_ENABLE, CfgDataW'(1));
    write_reg(REG_DEBOUNCE, '1);
    write_reg(REG_SHORT, '1);
    write_reg(REG_LONG, '1);
    send_tick(1'b1, 1'b0);
    repeat (WIDE_TICKS) send_tick(1'b0, 1'b0);
    run_phase(1'b1, pick_delay(), pick_delay(), pick_delay(), 75);

    settle();
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        // Keep the sender going while this side blocks, so the pipeline fills
        hold_out = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_res.size() == 0) begin
        $error("result transfer with nothing owed");
        fail_cnt++;
      end else begin
        want_r = awaited_res.pop_front();
        if (out_if.short_press !== want_r.short_press) begin
          $error("short_press: expected %0b, got %0b", want_r.short_press,
                 out_if.short_press);
          fail_cnt++;
        end
        if (out_if.long_press !== want_r.long_press) begin
          $error("long_press: expected %0b, got %0b", want_r.long_press, out_if.long_press);
          fail_cnt++;
        end
        if (out_if.busy_res !== want_r.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want_r.busy_res, out_if.busy_res);
          fail_cnt++;
        end
      end
    end
  end

endmodule

[filelist.f]
src/bspc_pkg.sv
src/bspc_if.sv
src/bspc_cfg_regs.sv
src/bspc_eval.sv
src/bspc_out_reg.sv
src/button_short_long_press_classifier_top.sv
tb/sv/tb.sv
